>>> rtl/core/mpsp_pkg.sv
// Shared types, constants and helpers for the MQTT packet stream parser.
// No dependencies; imported by every module of the parser.
`timescale 1ns / 1ps

package mpsp_pkg;

    localparam int DATA_W               = 8;
    localparam int LEN_W                = 28;
    localparam int LEN_CNT_W            = 3;
    localparam int IDENT_W              = 16;
    localparam int TOPIC_W              = 16;
    localparam int CODE_W               = 8;
    localparam int NIB_W                = 4;
    localparam int ROLE_W               = 3;
    localparam int S_TDATA_W            = 8;
    localparam int M_TDATA_W            = 64;
    localparam int MAX_LENGTH_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH          = 2;
    localparam int QPTR_W               = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W               = $clog2(QUEUE_DEPTH + 1);

    // control packet type codes
    localparam logic [NIB_W-1:0] PKT_RESERVED_LO = 4'd0;
    localparam logic [NIB_W-1:0] PKT_CONNACK     = 4'd2;
    localparam logic [NIB_W-1:0] PKT_PUBLISH     = 4'd3;
    localparam logic [NIB_W-1:0] PKT_PUBACK      = 4'd4;
    localparam logic [NIB_W-1:0] PKT_PUBREC      = 4'd5;
    localparam logic [NIB_W-1:0] PKT_PUBREL      = 4'd6;
    localparam logic [NIB_W-1:0] PKT_PUBCOMP     = 4'd7;
    localparam logic [NIB_W-1:0] PKT_SUBACK      = 4'd9;
    localparam logic [NIB_W-1:0] PKT_UNSUBACK    = 4'd11;
    localparam logic [NIB_W-1:0] PKT_RESERVED_HI = 4'd15;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_HEADER    = 3'd0,
        ROLE_LENGTH    = 3'd1,
        ROLE_TOPIC_LEN = 3'd2,
        ROLE_TOPIC     = 3'd3,
        ROLE_IDENT     = 3'd4,
        ROLE_PAYLOAD   = 3'd5,
        ROLE_OTHER     = 3'd6,
        ROLE_IGNORED   = 3'd7
    } role_t;

    typedef enum logic [1:0] {
        ST_BUSY      = 2'd0,
        ST_OK        = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_HALTED    = 2'd3
    } status_t;

    // how the body of a packet type is laid out
    typedef enum logic [2:0] {
        BCL_OTHER   = 3'd0,
        BCL_CONNACK = 3'd1,
        BCL_PUBLISH = 3'd2,
        BCL_ID      = 3'd3,
        BCL_SUBACK  = 3'd4
    } body_class_t;

    // classified input transaction
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              restart;
        logic              bad_type;  // as a header byte: reserved type
        logic              cont;      // as a length byte: continuation bit
        body_class_t       cls;       // as a header byte: body layout
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        role_t              role;
        logic               pkt_end;
        logic [NIB_W-1:0]   kind;
        logic [NIB_W-1:0]   flags;
        logic [IDENT_W-1:0] ident;
        logic [CODE_W-1:0]  code;
        logic [TOPIC_W-1:0] topic;
        logic               ack;
        status_t            status;
    } result_t;

    function automatic body_class_t classify_kind(input logic [NIB_W-1:0] kind);
        body_class_t cls;
        unique case (kind)
            PKT_CONNACK:  cls = BCL_CONNACK;
            PKT_PUBLISH:  cls = BCL_PUBLISH;
            PKT_PUBACK,
            PKT_PUBREC,
            PKT_PUBREL,
            PKT_PUBCOMP,
            PKT_UNSUBACK: cls = BCL_ID;
            PKT_SUBACK:   cls = BCL_SUBACK;
            default:      cls = BCL_OTHER;
        endcase
        return cls;
    endfunction

    function automatic logic [1:0] min_body(input body_class_t cls);
        logic [1:0] n;
        unique case (cls)
            BCL_CONNACK,
            BCL_PUBLISH,
            BCL_ID:      n = 2'd2;
            BCL_SUBACK:  n = 2'd3;
            default:     n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/mpsp_front.sv
// Front stage: accepts input transactions and classifies each byte.
// Depends on mpsp_pkg.
`timescale 1ns / 1ps

module mpsp_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mpsp_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic                         s_tuser,    // [0] restart
    output logic                         q_valid,
    input  logic                         q_ready,
    output mpsp_pkg::item_t              q_item
);
    import mpsp_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    always_comb begin
        item_next.data     = s_tdata[DATA_W-1:0];
        item_next.restart  = s_tuser;
        item_next.bad_type = (s_tdata[7:4] == PKT_RESERVED_LO) ||
                             (s_tdata[7:4] == PKT_RESERVED_HI);
        item_next.cont     = s_tdata[7];
        item_next.cls      = classify_kind(s_tdata[7:4]);
    end

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

>>> rtl/core/mpsp_queue.sv
// Short queue of classified bytes between the front and back stages.
// Depends on mpsp_pkg.
`timescale 1ns / 1ps

module mpsp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mpsp_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output mpsp_pkg::item_t out_item
);
    import mpsp_pkg::*;

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/core/mpsp_back.sv
// Back stage: packet parser state machine and the result output register.
// Depends on mpsp_pkg.
`timescale 1ns / 1ps

module mpsp_back #(
    parameter int MAX_LENGTH_BYTES = mpsp_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mpsp_pkg::item_t                in_item,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mpsp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [mpsp_pkg::ROLE_W-1:0]    m_tuser,
    output logic                           m_tlast
);
    import mpsp_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    phase_t                 phase_reg, phase_cur, phase_next;
    logic [NIB_W-1:0]       kind_reg, kind_cur, kind_next;
    logic [NIB_W-1:0]       flags_reg, flags_cur, flags_next;
    body_class_t            cls_reg, cls_cur, cls_next;
    logic [LEN_W-1:0]       rem_reg, rem_cur, rem_next;
    logic [LEN_CNT_W-1:0]   lcnt_reg, lcnt_cur, lcnt_next;
    logic [LEN_W-1:0]       bcnt_reg, bcnt_cur, bcnt_next;
    logic [TOPIC_W-1:0]     topic_reg, topic_cur, topic_next;
    logic [IDENT_W-1:0]     ident_reg, ident_cur, ident_next;
    logic [CODE_W-1:0]      code_reg, code_cur, code_next;
    logic                   halted_reg, halted_cur, halted_next;

    logic                   out_valid_reg;
    result_t                res_reg;
    result_t                res;
    logic                   step;

    logic [DATA_W-1:0]      b;
    logic [5:0]             shamt;
    logic                   qos;
    logic                   do_fail;
    logic                   do_done;
    logic [TOPIC_W:0]       tend;
    logic [TOPIC_W+1:0]     need;

    assign in_ready = !out_valid_reg || m_tready;
    assign step     = in_valid && in_ready;
    assign b        = in_item.data;

    // restart acts as a reset applied before this byte
    always_comb begin
        if (in_item.restart) begin
            phase_cur  = PH_HEADER;
            kind_cur   = '0;
            flags_cur  = '0;
            cls_cur    = BCL_OTHER;
            rem_cur    = '0;
            lcnt_cur   = '0;
            bcnt_cur   = '0;
            topic_cur  = '0;
            ident_cur  = '0;
            code_cur   = '0;
            halted_cur = 1'b0;
        end else begin
            phase_cur  = phase_reg;
            kind_cur   = kind_reg;
            flags_cur  = flags_reg;
            cls_cur    = cls_reg;
            rem_cur    = rem_reg;
            lcnt_cur   = lcnt_reg;
            bcnt_cur   = bcnt_reg;
            topic_cur  = topic_reg;
            ident_cur  = ident_reg;
            code_cur   = code_reg;
            halted_cur = halted_reg;
        end
    end

    always_comb begin
        phase_next  = phase_cur;
        kind_next   = kind_cur;
        flags_next  = flags_cur;
        cls_next    = cls_cur;
        rem_next    = rem_cur;
        lcnt_next   = lcnt_cur;
        bcnt_next   = bcnt_cur;
        topic_next  = topic_cur;
        ident_next  = ident_cur;
        code_next   = code_cur;
        halted_next = halted_cur;
        do_fail     = 1'b0;
        do_done     = 1'b0;
        qos         = (flags_cur[2:1] != 2'b00);
        shamt       = {lcnt_cur, 3'b000} - {3'b000, lcnt_cur};  // 7 * count
        tend        = (TOPIC_W+1)'(2) + {1'b0, topic_cur};
        need        = '0;

        res         = '0;
        res.data    = b;
        res.role    = ROLE_HEADER;
        res.status  = ST_BUSY;

        if (halted_cur) begin
            res.role   = ROLE_IGNORED;
            res.status = ST_HALTED;
        end else begin
            unique case (phase_cur)
                PH_LENGTH: begin
                    res.role  = ROLE_LENGTH;
                    rem_next  = rem_cur | (LEN_W'(b[6:0]) << shamt);
                    lcnt_next = lcnt_cur + 1'b1;
                    if (in_item.cont) begin
                        if (lcnt_next >= LEN_CNT_W'(MAX_LENGTH_BYTES)) do_fail = 1'b1;
                    end else begin
                        bcnt_next = '0;
                        if (rem_next < LEN_W'(min_body(cls_cur))) begin
                            do_fail = 1'b1;
                        end else if (rem_next == '0) begin
                            do_done = 1'b1;
                        end else begin
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    res.role = ROLE_OTHER;
                    unique case (cls_cur)
                        BCL_CONNACK: begin
                            if (bcnt_cur == LEN_W'(1)) code_next = b;
                        end
                        BCL_PUBLISH: begin
                            if (bcnt_cur < LEN_W'(2)) begin
                                res.role = ROLE_TOPIC_LEN;
                                if (bcnt_cur == '0) topic_next = {b, 8'h00};
                                else                topic_next = topic_cur | {8'h00, b};
                            end else if (bcnt_cur < LEN_W'(tend)) begin
                                res.role = ROLE_TOPIC;
                            end else if (qos && (bcnt_cur < LEN_W'(tend) + LEN_W'(2))) begin
                                res.role = ROLE_IDENT;
                                if (bcnt_cur == LEN_W'(tend)) ident_next = {b, 8'h00};
                                else                          ident_next = ident_cur | {8'h00, b};
                            end else begin
                                res.role = ROLE_PAYLOAD;
                            end
                        end
                        BCL_ID,
                        BCL_SUBACK: begin
                            if (bcnt_cur == '0) begin
                                res.role   = ROLE_IDENT;
                                ident_next = {b, 8'h00};
                            end else if (bcnt_cur == LEN_W'(1)) begin
                                res.role   = ROLE_IDENT;
                                ident_next = ident_cur | {8'h00, b};
                            end else if (cls_cur == BCL_SUBACK && bcnt_cur == LEN_W'(2)) begin
                                code_next = b;
                            end
                        end
                        default: ;
                    endcase
                    bcnt_next = bcnt_cur + 1'b1;
                    need      = (TOPIC_W+2)'(2) + {2'b00, topic_next} +
                                (qos ? (TOPIC_W+2)'(2) : '0);
                    if (cls_cur == BCL_PUBLISH && bcnt_cur == LEN_W'(1) &&
                        rem_cur < LEN_W'(need)) begin
                        do_fail = 1'b1;
                    end else if (bcnt_next >= rem_cur) begin
                        do_done = 1'b1;
                    end
                end
                default: begin
                    // header byte: a fresh packet starts here
                    res.role   = ROLE_HEADER;
                    kind_next  = b[7:4];
                    flags_next = b[3:0];
                    cls_next   = in_item.cls;
                    rem_next   = '0;
                    lcnt_next  = '0;
                    bcnt_next  = '0;
                    topic_next = '0;
                    ident_next = '0;
                    code_next  = '0;
                    if (in_item.bad_type) do_fail = 1'b1;
                    else                  phase_next = PH_LENGTH;
                end
            endcase

            if (do_fail) begin
                halted_next = 1'b1;
                phase_next  = PH_HEADER;
                res.pkt_end = 1'b1;
                res.kind    = kind_next;
                res.flags   = flags_next;
                res.status  = ST_MALFORMED;
            end else if (do_done) begin
                phase_next  = PH_HEADER;
                res.pkt_end = 1'b1;
                res.kind    = kind_next;
                res.flags   = flags_next;
                res.ident   = ident_next;
                res.code    = code_next;
                res.status  = ST_OK;
                if (cls_cur == BCL_PUBLISH) begin
                    res.topic = topic_next;
                    res.ack   = (flags_cur[2:1] == 2'b01);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            kind_reg      <= '0;
            flags_reg     <= '0;
            cls_reg       <= BCL_OTHER;
            rem_reg       <= '0;
            lcnt_reg      <= '0;
            bcnt_reg      <= '0;
            topic_reg     <= '0;
            ident_reg     <= '0;
            code_reg      <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                phase_reg  <= phase_next;
                kind_reg   <= kind_next;
                flags_reg  <= flags_next;
                cls_reg    <= cls_next;
                rem_reg    <= rem_next;
                lcnt_reg   <= lcnt_next;
                bcnt_reg   <= bcnt_next;
                topic_reg  <= topic_next;
                ident_reg  <= ident_next;
                code_reg   <= code_next;
                halted_reg <= halted_next;
            end
            if (in_ready) out_valid_reg <= in_valid;
        end
        if (step) res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_reg.pkt_end;
    assign m_tuser  = res_reg.role;
    assign m_tdata  = {5'b00000, res_reg.status, res_reg.ack, res_reg.topic,
                       res_reg.code, res_reg.ident, res_reg.flags, res_reg.kind,
                       res_reg.data};

endmodule

>>> rtl/core/mqtt_packet_stream_parser.sv
// Top level of the MQTT 3.1.1 received-stream packet parser.
// Depends on mpsp_pkg, mpsp_front, mpsp_queue and mpsp_back.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata = data_byte, s_tuser = restart
// m_*       out  m_tvalid/m_tready  m_tdata = byte summary, m_tuser = byte_role,
//                                   m_tlast = packet_end
//
// One byte per cycle sustained while m_tready allows; each transaction yields
// exactly one result. The rate is set by the parser state update in the back stage.
// Each byte passes through the front register, the queue and the output register.
// aresetn is synchronous, active low; it clears parser state and empties the pipe.
// A stalled m_tready fills the output register, then the queue, then the front
// register before s_tready drops; no transaction is lost or repeated.

module mqtt_packet_stream_parser #(
    parameter int MAX_LENGTH_BYTES = mpsp_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mpsp_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // [0] restart
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] byte_echo, [11:8] packet_kind, [15:12] header_flags,
    // [31:16] packet_ident, [39:32] reply_code, [55:40] topic_size,
    // [56] ack_owed, [58:57] parse_status, [63:59] zero
    output logic [mpsp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [mpsp_pkg::ROLE_W-1:0]    m_tuser,   // [2:0] byte_role
    output logic                           m_tlast    // packet_end
);
    import mpsp_pkg::*;

    logic  fq_valid;
    logic  fq_ready;
    item_t fq_item;
    logic  qb_valid;
    logic  qb_ready;
    item_t qb_item;

    // front: accept and classify each byte
    mpsp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    // decoupling queue so either side can stall on its own
    mpsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // back: packet state machine and result register
    mpsp_back #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (qb_valid),
        .in_ready (qb_ready),
        .in_item  (qb_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/sv/mqtt_parse_checker.sv
// Checker for the MQTT packet stream parser: watches both stream channels,
// predicts each result from the accepted input bytes and compares it.
// Depends on mpsp_pkg for packet type codes, role and status enums.
`timescale 1ns / 1ps

module mqtt_parse_checker #(
    parameter int MAX_LEN_BYTES = mpsp_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [mpsp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mpsp_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [mpsp_pkg::ROLE_W-1:0]    m_tuser,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             pending,
    output int                             results_seen,
    output int                             packets_ok,
    output int                             packets_bad
);
    import mpsp_pkg::*;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_LEN,
        PH_BODY
    } parse_phase_t;

    parse_phase_t       ph;
    logic [NIB_W-1:0]   kind;
    logic [NIB_W-1:0]   flags;
    logic [LEN_W-1:0]   rem_len;
    logic [LEN_W-1:0]   body_cnt;
    logic [2:0]         len_cnt;
    logic [TOPIC_W-1:0] topic_bytes;
    logic [IDENT_W-1:0] ident;
    logic [CODE_W-1:0]  code;
    logic               halted;

    result_t expected_q[$];
    int      n_errors  = 0;
    int      n_pending = 0;
    int      n_results = 0;
    int      n_ok      = 0;
    int      n_bad     = 0;

    assign fail_count   = n_errors;
    assign pending      = n_pending;
    assign results_seen = n_results;
    assign packets_ok   = n_ok;
    assign packets_bad  = n_bad;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    task automatic clear_packet();
        ph          = PH_HDR;
        kind        = '0;
        flags       = '0;
        rem_len     = '0;
        len_cnt     = '0;
        body_cnt    = '0;
        topic_bytes = '0;
        ident       = '0;
        code        = '0;
    endtask

    function automatic logic [LEN_W-1:0] shortest_body(input logic [NIB_W-1:0] k);
        case (k)
            PKT_CONNACK, PKT_PUBLISH, PKT_PUBACK, PKT_PUBREC,
            PKT_PUBREL, PKT_PUBCOMP, PKT_UNSUBACK: return LEN_W'(2);
            PKT_SUBACK:                            return LEN_W'(3);
            default:                               return LEN_W'(0);
        endcase
    endfunction

    task automatic mark_malformed(inout result_t r);
        r.pkt_end = 1'b1;
        r.kind    = kind;
        r.flags   = flags;
        r.status  = ST_MALFORMED;
        halted    = 1'b1;
        ph        = PH_HDR;
    endtask

    task automatic mark_complete(inout result_t r);
        r.pkt_end = 1'b1;
        r.kind    = kind;
        r.flags   = flags;
        r.ident   = ident;
        r.code    = code;
        if (kind == PKT_PUBLISH) begin
            r.topic = topic_bytes;
            r.ack   = (flags[2:1] == 2'd1);
        end
        r.status = ST_OK;
        ph       = PH_HDR;
    endtask

    // role of one body byte; also captures topic length, id and return code
    task automatic classify_body_byte(input logic [7:0] b, input logic [LEN_W-1:0] idx,
                                      output role_t role);
        logic [31:0] tend;
        tend = 32'd2 + 32'(topic_bytes);
        case (kind)
            PKT_CONNACK: begin
                if (idx == 1) code = b;
                role = ROLE_OTHER;
            end
            PKT_PUBLISH: begin
                if (idx < 2) begin
                    if (idx == 0) topic_bytes = {b, 8'h00};
                    else          topic_bytes = topic_bytes | 16'(b);
                    role = ROLE_TOPIC_LEN;
                end else if (32'(idx) < tend) begin
                    role = ROLE_TOPIC;
                end else if (flags[2:1] != 2'd0 && 32'(idx) < tend + 32'd2) begin
                    if (32'(idx) == tend) ident = {b, 8'h00};
                    else                  ident = ident | 16'(b);
                    role = ROLE_IDENT;
                end else begin
                    role = ROLE_PAYLOAD;
                end
            end
            PKT_PUBACK, PKT_PUBREC, PKT_PUBREL, PKT_PUBCOMP, PKT_SUBACK, PKT_UNSUBACK: begin
                if (idx == 0) begin
                    ident = {b, 8'h00};
                    role  = ROLE_IDENT;
                end else if (idx == 1) begin
                    ident = ident | 16'(b);
                    role  = ROLE_IDENT;
                end else begin
                    if (kind == PKT_SUBACK && idx == 2) code = b;
                    role = ROLE_OTHER;
                end
            end
            default: role = ROLE_OTHER;
        endcase
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic restart, output result_t r);
        logic [LEN_W-1:0] idx;
        logic [31:0]      need;
        role_t            role;
        r        = '0;
        r.data   = b;
        r.role   = ROLE_HEADER;
        r.status = ST_BUSY;
        if (restart) begin
            clear_packet();
            halted = 1'b0;
        end
        if (halted) begin
            r.role   = ROLE_IGNORED;
            r.status = ST_HALTED;
        end else if (ph == PH_LEN) begin
            r.role  = ROLE_LENGTH;
            rem_len = LEN_W'(64'(rem_len) | (64'(b[6:0]) << (7 * int'(len_cnt))));
            len_cnt = len_cnt + 3'd1;
            if (b[7]) begin
                if (int'(len_cnt) >= MAX_LEN_BYTES) mark_malformed(r);
            end else begin
                body_cnt = '0;
                if (rem_len < shortest_body(kind)) mark_malformed(r);
                else if (rem_len == 0)             mark_complete(r);
                else                               ph = PH_BODY;
            end
        end else if (ph == PH_BODY) begin
            idx = body_cnt;
            classify_body_byte(b, idx, role);
            r.role   = role;
            body_cnt = body_cnt + 1'b1;
            need     = 32'd2 + 32'(topic_bytes) + ((flags[2:1] != 2'd0) ? 32'd2 : 32'd0);
            if (kind == PKT_PUBLISH && idx == 1 && 32'(rem_len) < need) begin
                mark_malformed(r);
            end else if (body_cnt >= rem_len) begin
                mark_complete(r);
            end
        end else begin
            clear_packet();
            kind  = b[7:4];
            flags = b[3:0];
            if (kind == PKT_RESERVED_LO || kind == PKT_RESERVED_HI) mark_malformed(r);
            else                                                   ph = PH_LEN;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            clear_packet();
            halted = 1'b0;
            expected_q.delete();
        end else begin
            // result side first: a result never belongs to a byte taken at this edge
            if (m_tvalid && m_tready) begin
                got.data    = m_tdata[7:0];
                got.kind    = m_tdata[11:8];
                got.flags   = m_tdata[15:12];
                got.ident   = m_tdata[31:16];
                got.code    = m_tdata[39:32];
                got.topic   = m_tdata[55:40];
                got.ack     = m_tdata[56];
                got.status  = status_t'(m_tdata[58:57]);
                got.role    = role_t'(m_tuser);
                got.pkt_end = m_tlast;
                n_results++;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result 0x%0h with no byte pending", m_tdata));
                end else begin
                    want = expected_q.pop_front();
                    check_field("byte_echo", got.data, want.data);
                    check_field("byte_role", got.role, want.role);
                    check_field("packet_end", got.pkt_end, want.pkt_end);
                    check_field("packet_kind", got.kind, want.kind);
                    check_field("header_flags", got.flags, want.flags);
                    check_field("packet_ident", got.ident, want.ident);
                    check_field("reply_code", got.code, want.code);
                    check_field("topic_size", got.topic, want.topic);
                    check_field("ack_owed", got.ack, want.ack);
                    check_field("parse_status", got.status, want.status);
                    check_field("tdata pad", m_tdata[63:59], '0);
                    if (want.status == ST_OK)        n_ok++;
                    if (want.status == ST_MALFORMED) n_bad++;
                end
            end
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tuser, want);
                expected_q.insert(expected_q.size(), want);
            end
        end
        n_pending = expected_q.size();
    end

endmodule

>>> tb/sv/mqtt_packet_stream_parser_tb.sv
// Testbench top for the MQTT packet stream parser: clock, reset, byte stimulus,
// result-side backpressure and the verdict. Depends on mpsp_pkg, the parser RTL
// and mqtt_parse_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module mqtt_packet_stream_parser_tb;
    import mpsp_pkg::*;

    localparam int CLK_HALF     = 10;    // 20 ns period
    localparam int RESET_CYCLES = 12;
    localparam int ITEM_TARGET  = 700;   // random-part bytes
    localparam int CALM_TAIL    = 120;   // last bytes sent with no idling
    localparam int DRAIN_CYCLES = 20;    // generous margin after the last result
    localparam int STALL_LIMIT  = 4000;  // cycles with no transaction on either side

    // packet types the package leaves unnamed
    localparam logic [NIB_W-1:0] PKT_CONNECT  = 4'd1;
    localparam logic [NIB_W-1:0] PKT_PINGRESP = 4'd13;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ROLE_W-1:0]    m_tuser;
    logic                 m_tlast;

    int chk_fails, chk_pending, chk_results, chk_ok, chk_bad;

    // stimulus control shared with the backpressure process
    bit   calm      = 1'b0;
    int   tx_pct    = 0;     // chance per byte of a sender gap
    int   rx_pct    = 0;     // chance per cycle of a receiver stall
    int   stall_left = 0;
    int   rx_tick   = 0;
    int   idle_cycles = 0;

    // one packet being built: {restart, byte} per transaction
    logic [8:0] pkt_q[$];
    logic [8:0] opening_seq[$];

    always #CLK_HALF aclk = ~aclk;

    mqtt_packet_stream_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] data_byte
        .s_tuser  (s_tuser),    // [0] restart
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] echo ... [58:57] status, see RTL header
        .m_tuser  (m_tuser),    // [2:0] byte_role
        .m_tlast  (m_tlast)     // packet_end
    );

    mqtt_parse_checker #(
        .MAX_LEN_BYTES (MAX_LENGTH_BYTES_DEF)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (chk_fails),
        .pending      (chk_pending),
        .results_seen (chk_results),
        .packets_ok   (chk_ok),
        .packets_bad  (chk_bad)
    );

    // Result-side backpressure: random stall bursts, with the stall chance re-drawn
    // from 0, 8 and 25 percent as rx_tick runs, so some stretches run with no stalls at all.
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 64 == 0) begin
            case ($urandom_range(0, 2))
                0:       rx_pct <= 0;
                1:       rx_pct <= 8;
                default: rx_pct <= 25;
            endcase
        end
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < rx_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("** mqtt_packet_stream_parser: FAILED **");
            $finish;
        end
    end

    // Drive one byte and hold it until the transaction completes. An optional
    // gap of idle cycles goes in front. s_tready is sampled at the
    // falling edge so the decision never races the DUT's own update.
    task automatic send_byte(input logic [7:0] b, input logic restart);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < tx_pct) gap = $urandom_range(1, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= restart;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        pkt_q.insert(pkt_q.size(), {1'b0, b});
    endtask

    // Remaining-length field; sometimes padded with zero continuation bytes,
    // which the parser accepts as long as no more than four bytes are used.
    task automatic push_length(input int v, input bit allow_pad);
        int nb;
        nb = (v < 128) ? 1 : (v < 16384) ? 2 : (v < 2097152) ? 3 : 4;
        if (allow_pad && $urandom_range(0, 6) == 0) nb = $urandom_range(nb, 4);
        for (int i = 0; i < nb; i++) begin
            push_byte(8'((v >> (7 * i)) & 'h7f) | ((i < nb - 1) ? 8'h80 : 8'h00));
        end
    endtask

    task automatic push_random(input int n);
        repeat (n) push_byte(8'($urandom));
    endtask

    function automatic logic [NIB_W-1:0] pick_sized_kind();
        case ($urandom_range(0, 7))
            0:       return PKT_CONNACK;
            1:       return PKT_PUBLISH;
            2:       return PKT_PUBACK;
            3:       return PKT_PUBREC;
            4:       return PKT_PUBREL;
            5:       return PKT_PUBCOMP;
            6:       return PKT_SUBACK;
            default: return PKT_UNSUBACK;
        endcase
    endfunction

    // A well-formed packet of random type, flags and content.
    task automatic build_good_packet();
        logic [NIB_W-1:0]   k;
        logic [NIB_W-1:0]   fl;
        logic [TOPIC_W-1:0] tl;
        logic [7:0]         body[$];
        int                 n;
        k  = ($urandom_range(0, 99) < 25) ? PKT_PUBLISH : 4'($urandom_range(1, 14));
        fl = 4'($urandom);
        case (k)
            PKT_CONNACK: n = 2 + $urandom_range(0, 2);
            PKT_SUBACK:  n = 3 + $urandom_range(0, 2);
            PKT_PUBACK, PKT_PUBREC, PKT_PUBREL, PKT_PUBCOMP, PKT_UNSUBACK:
                         n = 2 + $urandom_range(0, 2);
            PKT_PUBLISH: n = 0;
            default:     n = $urandom_range(0, 4);    // zero means empty body
        endcase
        repeat (n) body.insert(body.size(), 8'($urandom));
        if (k == PKT_PUBLISH) begin
            // rare long topics, up to 300 bytes, can reach the high byte of the topic length
            tl = ($urandom_range(0, 99) < 4) ? 16'($urandom_range(128, 300))
                                             : 16'($urandom_range(0, 6));
            body.insert(body.size(), tl[15:8]);
            body.insert(body.size(), tl[7:0]);
            repeat (int'(tl)) body.insert(body.size(), 8'($urandom));
            if (fl[2:1] != 2'd0) repeat (2) body.insert(body.size(), 8'($urandom));
            n = ($urandom_range(0, 99) < 4) ? $urandom_range(100, 200) : $urandom_range(0, 8);
            repeat (n) body.insert(body.size(), 8'($urandom));
        end
        push_byte({k, fl});
        push_length(body.size(), 1'b1);
        foreach (body[i]) push_byte(body[i]);
    endtask

    // Malformed input or noise; the parser may be left halted or mid-packet.
    task automatic build_broken_packet();
        logic [NIB_W-1:0] k;
        logic [1:0]       qos;
        int               tl;
        int               lim;
        case ($urandom_range(0, 5))
            0: begin    // reserved type, then bytes the halted parser ignores
                k = $urandom_range(0, 1) ? PKT_RESERVED_HI : PKT_RESERVED_LO;
                push_byte({k, 4'($urandom)});
                push_random($urandom_range(0, 3));
            end
            1: begin    // continuation bit still set on the last allowed length byte
                push_byte({4'($urandom_range(1, 14)), 4'($urandom)});
                repeat (4) push_byte({1'b1, 7'($urandom)});
                push_random($urandom_range(0, 2));
            end
            2: begin    // body shorter than its type needs
                k = pick_sized_kind();
                push_byte({k, 4'($urandom)});
                push_length($urandom_range(0, (k == PKT_SUBACK) ? 2 : 1), 1'b1);
                push_random($urandom_range(0, 2));
            end
            3: begin    // PUBLISH whose topic and id do not fit the body
                qos = 2'($urandom);
                tl  = $urandom_range(1, 20);
                lim = 2 + tl + ((qos != 2'd0) ? 2 : 0);
                push_byte({PKT_PUBLISH, 1'b0, qos, 1'b0});
                push_length($urandom_range(2, lim - 1), 1'b0);
                push_byte(8'(tl >> 8));
                push_byte(8'(tl));
                push_random($urandom_range(0, 2));
            end
            4: begin    // huge remaining length, cut short by the next restart
                push_byte({4'($urandom_range(1, 14)), 4'($urandom)});
                push_byte({1'b1, 7'($urandom)});
                push_byte({1'b1, 7'($urandom)});
                push_byte({1'b1, 7'($urandom)});
                push_byte({1'b0, 7'($urandom)});
                push_random($urandom_range(0, 6));
            end
            default: begin    // raw noise, restart set now and then
                repeat ($urandom_range(1, 6)) begin
                    pkt_q.insert(pkt_q.size(), {($urandom_range(0, 9) == 0), 8'($urandom)});
                end
            end
        endcase
    endtask

    initial begin
        int  sent;
        int  packets;
        bit  need_restart;
        bit  first_restart;
        bit  broken;
        sent    = 0;
        packets = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: {restart, byte} per transaction.
        opening_seq = '{
            // PUBLISH QoS 1, empty topic, id 0x1234: PUBACK owed
            {1'b0, PKT_PUBLISH, 4'h2}, 9'h004, 9'h000, 9'h000, 9'h012, 9'h034,
            // SUBACK with id and return code
            {1'b0, PKT_SUBACK, 4'h0}, 9'h003, 9'h0ab, 9'h0cd, 9'h080,
            // empty body ends on the length byte
            {1'b0, PKT_PINGRESP, 4'h0}, 9'h000,
            // reserved type 15, then an ignored byte while halted
            {1'b0, PKT_RESERVED_HI, 4'hf}, 9'h0ff,
            // restart straight into reserved type 0
            {1'b1, PKT_RESERVED_LO, 4'h0},
            // restart, four length bytes all with continuation
            {1'b1, PKT_CONNECT, 4'h0}, 9'h0ff, 9'h080, 9'h0ff, 9'h0ff,
            // restart, PUBACK with a one-byte body
            {1'b1, PKT_PUBACK, 4'h0}, 9'h001,
            // restart, PUBLISH QoS 2 whose topic length overruns the body
            {1'b1, PKT_PUBLISH, 4'h4}, 9'h003, 9'h000, 9'h005
        };
        foreach (opening_seq[i]) send_byte(opening_seq[i][7:0], opening_seq[i][8]);

        // Random part: mostly well-formed packets, some broken ones and noise.
        need_restart = 1'b1;
        while (sent < ITEM_TARGET) begin
            if (packets % 8 == 0) begin
                case ($urandom_range(0, 2))
                    0:       tx_pct = 0;
                    1:       tx_pct = 10;
                    default: tx_pct = 30;
                endcase
            end
            calm = (sent > ITEM_TARGET - CALM_TAIL);
            pkt_q.delete();
            broken = ($urandom_range(0, 99) < 15);
            if (broken) build_broken_packet();
            else        build_good_packet();
            first_restart = need_restart || ($urandom_range(0, 19) == 0);
            foreach (pkt_q[i]) begin
                send_byte(pkt_q[i][7:0], pkt_q[i][8] | ((i == 0) ? first_restart : 1'b0));
            end
            // after anything broken the parser state is unknown: resync
            need_restart = broken;
            sent += pkt_q.size();
            packets++;
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every expected result, then a few more cycles.
        do @(negedge aclk); while (chk_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d results checked over %0d packet attempts", chk_results, packets);
        $display("run: %0d packets completed, %0d malformed", chk_ok, chk_bad);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("** mqtt_packet_stream_parser: PASSED **");
        end else begin
            $display("** mqtt_packet_stream_parser: FAILED **");
        end
        $finish;
    end

endmodule
